// ===== rtl/svns_pkg.sv =====
// ----------------------------------------------------------------------------
// svns_pkg: shared types and constants of the square-wave voice and noise synth
// Command codes, field widths, the master gain table and the voice control word.
// ----------------------------------------------------------------------------
`default_nettype none

package svns_pkg;

  // Command codes of an input request
  typedef enum logic [1:0] {
    CMD_TICK    = 2'd0,
    CMD_NOTE_ON = 2'd1,
    CMD_REST    = 2'd2,
    CMD_NOISE   = 2'd3
  } cmd_e;

  // Field and state widths
  localparam int unsigned CMD_W        = 2;
  localparam int unsigned VOICE_W      = 2;
  localparam int unsigned PHASE_W      = 16;
  localparam int unsigned LEVEL_W      = 8;
  localparam int unsigned ENV_W        = 16;
  localparam int unsigned AMP_W        = 9;   // signed +/- envelope/256
  localparam int unsigned NOISE_W      = 31;
  localparam int unsigned NOISE_PART_W = 7;   // signed +/- amplitude/4
  localparam int unsigned SAMPLE_W     = 16;
  localparam int unsigned VOL_W        = 2;
  localparam int unsigned GAIN_W       = 6;

  localparam logic [NOISE_W-1:0] NOISE_SEED = 31'h0000_ACE1;
  localparam int                 SAT_LIMIT  = 32000;
  localparam logic [VOL_W-1:0]   VOL_RESET  = 2'd2;

  // Master gain per volume level
  localparam logic [GAIN_W-1:0] GAIN_TABLE [4] = '{6'd0, 6'd14, 6'd28, 6'd46};

  // Per-voice control for one processed request
  typedef struct packed {
    logic tick;   // advance and decay
    logic load;   // note on for this voice
    logic clear;  // rest for this voice
  } voice_ctrl_t;

endpackage

`default_nettype wire

// ===== rtl/svns_if.sv =====
// ----------------------------------------------------------------------------
// svns_if: request and sample channels of the synth
// Valid/ready channels; a transfer happens when valid and ready are both high.
// ----------------------------------------------------------------------------
`default_nettype none

interface svns_cmd_if;
  logic        valid;
  logic        ready;
  logic [1:0]  command;
  logic [1:0]  voice;
  logic [15:0] phase_step;
  logic [7:0]  level;
  logic [7:0]  noise_level;

  modport source (output valid, command, voice, phase_step, level, noise_level,
                  input ready);
  modport sink   (input valid, command, voice, phase_step, level, noise_level,
                  output ready);
endinterface

interface svns_smp_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] sample;

  modport source (output valid, sample, input ready);
  modport sink   (input valid, sample, output ready);
endinterface

`default_nettype wire

// ===== rtl/svns_voice.sv =====
// ----------------------------------------------------------------------------
// svns_voice: one square-wave tone voice
// Holds phase, step, 8.8 envelope and decay; gives the signed contribution of
// the current tick and updates its state on each processed request.
// ----------------------------------------------------------------------------
`default_nettype none

module svns_voice
  import svns_pkg::*;
#(
  parameter int unsigned DECAY_W = 5
) (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire voice_ctrl_t               ctrl_i,
  input  wire logic [PHASE_W-1:0]        step_i,
  input  wire logic [ENV_W-1:0]          env_i,
  input  wire logic [DECAY_W-1:0]        decay_i,
  output logic signed [AMP_W-1:0]        amp_o
);

  logic [PHASE_W-1:0] phase_q, phase_d;
  logic [PHASE_W-1:0] step_q, step_d;
  logic [ENV_W-1:0]   env_q, env_d;
  logic [DECAY_W-1:0] decay_q, decay_d;

  logic               sounding;
  logic [PHASE_W-1:0] phase_next;
  logic [ENV_W-1:0]   env_decayed;
  logic [AMP_W-1:0]   amp_mag;

  // Advance the phase and decay the envelope with a floor at zero
  always_comb begin
    sounding    = (env_q != '0);
    phase_next  = phase_q + step_q;
    env_decayed = (env_q > ENV_W'(decay_q)) ? (env_q - ENV_W'(decay_q)) : '0;
    amp_mag     = AMP_W'(env_q[ENV_W-1:8]);
    if (!sounding) begin
      amp_o = '0;
    end else if (phase_next[PHASE_W-1]) begin
      amp_o = $signed(amp_mag);
    end else begin
      amp_o = -$signed(amp_mag);
    end
  end

  // Pick the next state for the processed request
  always_comb begin
    phase_d = phase_q;
    step_d  = step_q;
    env_d   = env_q;
    decay_d = decay_q;
    if (ctrl_i.tick && sounding) begin
      phase_d = phase_next;
      env_d   = env_decayed;
    end else if (ctrl_i.load) begin
      step_d  = step_i;
      env_d   = env_i;
      decay_d = decay_i;
    end else if (ctrl_i.clear) begin
      env_d   = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= '0;
      step_q  <= '0;
      env_q   <= '0;
      decay_q <= '0;
    end else begin
      phase_q <= phase_d;
      step_q  <= step_d;
      env_q   <= env_d;
      decay_q <= decay_d;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/svns_noise.sv =====
// ----------------------------------------------------------------------------
// svns_noise: 31-bit LFSR noise source
// Steps the LFSR on a tick while the amplitude is nonzero and gives
// plus or minus amplitude/4.
// ----------------------------------------------------------------------------
`default_nettype none

module svns_noise
  import svns_pkg::*;
(
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        tick_i,
  input  wire logic                        set_i,
  input  wire logic [LEVEL_W-1:0]          level_i,
  output logic signed [NOISE_PART_W-1:0]   part_o
);

  logic [NOISE_W-1:0] shift_q, shift_d;
  logic [LEVEL_W-1:0] amp_q, amp_d;
  logic               active;
  logic [NOISE_W-1:0] shift_next;
  logic [NOISE_PART_W-1:0] part_mag;

  // Shift right, feed bit 0 xor bit 1 back in at the top
  always_comb begin
    active     = (amp_q != '0);
    shift_next = {shift_q[0] ^ shift_q[1], shift_q[NOISE_W-1:1]};
    part_mag   = NOISE_PART_W'(amp_q[LEVEL_W-1:2]);
    if (!active) begin
      part_o = '0;
    end else if (shift_next[0]) begin
      part_o = $signed(part_mag);
    end else begin
      part_o = -$signed(part_mag);
    end
  end

  always_comb begin
    shift_d = shift_q;
    amp_d   = amp_q;
    if (tick_i && active) begin
      shift_d = shift_next;
    end
    if (set_i) begin
      amp_d = level_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      shift_q <= NOISE_SEED;
      amp_q   <= '0;
    end else begin
      shift_q <= shift_d;
      amp_q   <= amp_d;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/svns_mixer.sv =====
// ----------------------------------------------------------------------------
// svns_mixer: mix, gain, saturate and the sample output register
// Sums the voice and noise contributions, applies the master gain, clamps to
// +/-32000 and holds the sample until the sink takes it.
// ----------------------------------------------------------------------------
`default_nettype none

module svns_mixer
  import svns_pkg::*;
#(
  parameter int unsigned VOICE_COUNT = 3
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          tick_i,
  input  wire logic [VOL_W-1:0]              volume_i,
  input  wire logic signed [AMP_W-1:0]       voice_amp_i [VOICE_COUNT],
  input  wire logic signed [NOISE_PART_W-1:0] noise_part_i,
  output logic                               room_o,
  svns_smp_if.source                         smp_o
);

  localparam int unsigned SumW  = $clog2(VOICE_COUNT * 255 + 63 + 1) + 1;
  localparam int unsigned ProdW = SumW + GAIN_W + 1;
  localparam logic signed [ProdW-1:0] SatHi = ProdW'(SAT_LIMIT);
  localparam logic signed [ProdW-1:0] SatLo = -SatHi;

  logic signed [SumW-1:0]     acc;
  logic signed [ProdW-1:0]    prod;
  logic signed [SAMPLE_W-1:0] sat;
  logic                       valid_q, valid_d;
  logic signed [SAMPLE_W-1:0] sample_q, sample_d;

  // Sum the contributions, scale and clamp
  always_comb begin
    acc = SumW'(noise_part_i);
    for (int i = 0; i < VOICE_COUNT; i++) begin
      acc = acc + SumW'(voice_amp_i[i]);
    end
    prod = ProdW'(acc) * $signed({1'b0, GAIN_TABLE[volume_i]});
    if (prod > SatHi) begin
      sat = SAMPLE_W'(SatHi);
    end else if (prod < SatLo) begin
      sat = SAMPLE_W'(SatLo);
    end else begin
      sat = SAMPLE_W'(prod);
    end
  end

  // Load a new sample on a tick, drop it once taken
  always_comb begin
    room_o   = !valid_q || smp_o.ready;
    valid_d  = valid_q;
    sample_d = sample_q;
    if (tick_i) begin
      valid_d  = 1'b1;
      sample_d = sat;
    end else if (smp_o.ready) begin
      valid_d  = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    sample_q <= sample_d;
  end

  assign smp_o.valid  = valid_q;
  assign smp_o.sample = sample_q;

endmodule

`default_nettype wire

// ===== rtl/square_voice_noise_synth.sv =====
// A request is registered on acceptance and then processed; a held tick waits
// for output room, then loads its sample into the output register.
// Throughput: one request per cycle unless a tick waits for output room, set by
// the single pass from the input register via the voice, noise and mixer logic.
// Reset (asynchronous, active low) clears all voices and the noise level,
// seeds the LFSR with 0xACE1 and sets the volume level to 2.
// ----------------------------------------------------------------------------
// square_voice_noise_synth: three-voice square-wave synth with LFSR noise
// Input request register, per-voice lanes, noise source and sample mixer.
// ----------------------------------------------------------------------------
`default_nettype none

module square_voice_noise_synth
  import svns_pkg::*;
#(
  parameter int unsigned VOICE_COUNT  = 3,
  parameter int unsigned DECAY_LENGTH = 2880
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             cfg_we_i,
  input  wire logic [VOL_W-1:0] cfg_data_i,
  svns_cmd_if.sink              cmd_i,
  svns_smp_if.source            smp_o
);

  localparam int unsigned DecayW = $clog2((255 * 256) / DECAY_LENGTH + 1);

  // Input request register
  logic                 in_valid_q, in_valid_d;
  logic [CMD_W-1:0]     cmd_q;
  logic [VOICE_W-1:0]   voice_q;
  logic [PHASE_W-1:0]   step_q;
  logic [LEVEL_W-1:0]   level_q;
  logic [LEVEL_W-1:0]   nlevel_q;
  logic [VOL_W-1:0]     volume_q;

  logic                 room;
  logic                 proc;
  logic                 take;
  logic                 is_tick;
  logic [DecayW-1:0]    decay_lut [256];
  logic [DecayW-1:0]    decay;
  logic signed [AMP_W-1:0]        voice_amp [VOICE_COUNT];
  logic signed [NOISE_PART_W-1:0] noise_part;

  // Process the held request; a tick waits for output room for its sample
  always_comb begin
    is_tick     = (cmd_q == CMD_TICK);
    proc        = in_valid_q && (!is_tick || room);
    cmd_i.ready = !in_valid_q || proc;
    take        = cmd_i.valid && cmd_i.ready;
    in_valid_d  = take ? 1'b1 : (proc ? 1'b0 : in_valid_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
      volume_q   <= VOL_RESET;
    end else begin
      in_valid_q <= in_valid_d;
      if (cfg_we_i) begin
        volume_q <= cfg_data_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      cmd_q    <= cmd_i.command;
      voice_q  <= cmd_i.voice;
      step_q   <= cmd_i.phase_step;
      level_q  <= cmd_i.level;
      nlevel_q <= cmd_i.noise_level;
    end
  end

  // Decay per level: max(1, level*256/DECAY_LENGTH)
  for (genvar g = 0; g < 256; g++) begin : g_decay
    localparam int unsigned DecVal = (g * 256) / DECAY_LENGTH;
    assign decay_lut[g] = (DecVal == 0) ? DecayW'(1) : DecayW'(DecVal);
  end
  assign decay = decay_lut[level_q];

  // Voice lanes
  for (genvar v = 0; v < VOICE_COUNT; v++) begin : g_voice
    voice_ctrl_t ctrl;
    logic        hit;
    assign hit        = (32'(voice_q) == v);
    assign ctrl.tick  = proc && is_tick;
    assign ctrl.load  = proc && hit && (cmd_q == CMD_NOTE_ON);
    assign ctrl.clear = proc && hit && (cmd_q == CMD_REST);

    svns_voice #(
      .DECAY_W (DecayW)
    ) u_voice (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .ctrl_i  (ctrl),
      .step_i  (step_q),
      .env_i   ({level_q, 8'h00}),
      .decay_i (decay),
      .amp_o   (voice_amp[v])
    );
  end

  svns_noise u_noise (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .tick_i  (proc && is_tick),
    .set_i   (proc && (cmd_q == CMD_NOISE)),
    .level_i (nlevel_q),
    .part_o  (noise_part)
  );

  svns_mixer #(
    .VOICE_COUNT (VOICE_COUNT)
  ) u_mixer (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .tick_i       (proc && is_tick),
    .volume_i     (volume_q),
    .voice_amp_i  (voice_amp),
    .noise_part_i (noise_part),
    .room_o       (room),
    .smp_o        (smp_o)
  );

`ifndef NO_ASSERTIONS
  // A presented sample stays within the saturation limits
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    smp_o.valid |-> (smp_o.sample <= 16'sd32000 && smp_o.sample >= -16'sd32000))
    else $error("sample beyond saturation limit");

  // A held request that cannot be processed stays in the input register
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_q && !proc) |=> (in_valid_q && $stable(cmd_q) && $stable(voice_q)))
    else $error("pending request lost");

  // A processed tick always presents a sample in the next cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (proc && is_tick) |=> smp_o.valid)
    else $error("tick produced no sample");

  // No request is taken while a tick waits for output room
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_q && is_tick && !room) |-> !cmd_i.ready)
    else $error("request taken while tick stalled");
`endif

endmodule

`default_nettype wire
